// ===== hdl/cmt_pkg.sv =====
package cmt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam logic [2:0] OP_ADD_ID      = 3'd0;
    localparam logic [2:0] OP_LOOKUP_ID   = 3'd1;
    localparam logic [2:0] OP_DELETE_ID   = 3'd2;
    localparam logic [2:0] OP_ADD_PORT    = 3'd3;
    localparam logic [2:0] OP_FIND_BOUNCE = 3'd4;
    localparam logic [2:0] OP_FIND_SOURCE = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic KIND_ID   = 1'b0;
    localparam logic KIND_PORT = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] key_id;
        logic [31:0] address;
        logic [15:0] source_port;
        logic [15:0] relay_port;
    } entry_data_t;

    typedef struct packed {
        logic        valid;
        entry_data_t data;
    } entry_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] key_id;
        logic [31:0] address;
        logic [15:0] source_port;
        logic [15:0] relay_port;
    } query_t;

    // Search result riding down the chain with the wave.
    typedef struct packed {
        logic        hit;
        logic [31:0] address;
        logic [15:0] source_port;
        logic [15:0] relay_port;
    } carry_t;

    typedef struct packed {
        logic insert;
        logic remove;
    } cell_cmd_t;

endpackage

// ===== hdl/cmt_cell.sv =====
module cmt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  cmt_pkg::query_t    query,
    input  cmt_pkg::cell_cmd_t cmd,
    input  logic               wave_in,
    input  cmt_pkg::carry_t    carry_in,
    input  cmt_pkg::entry_t    prev_entry,
    input  cmt_pkg::entry_t    next_entry,
    output cmt_pkg::entry_t    entry,
    output logic               wave_out,
    output cmt_pkg::carry_t    carry_out
);
    import cmt_pkg::*;

    logic        valid_reg;
    entry_data_t data_reg;
    logic        wave_reg;
    carry_t      carry_reg;
    logic        remove_reg;
    logic        match;
    carry_t      carry_next;

    always_comb
    begin
        match = 1'b0;
        case (query.opcode)
            OP_LOOKUP_ID, OP_DELETE_ID:
                match = (data_reg.kind == KIND_ID) && (data_reg.key_id == query.key_id);
            OP_FIND_BOUNCE:
                match = (data_reg.kind == KIND_PORT)
                        && (data_reg.relay_port == query.relay_port);
            OP_FIND_SOURCE:
                match = (data_reg.kind == KIND_PORT)
                        && (data_reg.source_port == query.source_port)
                        && (data_reg.address == query.address);
            default:
                match = 1'b0;
        endcase
        match = match && valid_reg;
    end

    // Keep the newest hit from upstream; otherwise offer our own entry.
    always_comb
    begin
        carry_next = carry_in;
        if (!carry_in.hit && match)
        begin
            carry_next.hit         = 1'b1;
            carry_next.address     = data_reg.address;
            carry_next.source_port = data_reg.source_port;
            carry_next.relay_port  = data_reg.relay_port;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            wave_reg  <= 1'b0;
        end
        else
        begin
            wave_reg <= wave_in;
            if (cmd.insert)
                valid_reg <= prev_entry.valid;
            else if (cmd.remove && remove_reg)
                valid_reg <= next_entry.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert)
            data_reg <= prev_entry.data;
        else if (cmd.remove && remove_reg)
            data_reg <= next_entry.data;
        // Mark cells at or past the newest hit; they close the gap on delete.
        if (wave_in)
        begin
            carry_reg  <= carry_next;
            remove_reg <= carry_next.hit;
        end
    end

    assign entry.valid = valid_reg;
    assign entry.data  = data_reg;
    assign wave_out    = wave_reg;
    assign carry_out   = carry_reg;

endmodule

// ===== hdl/connection_mapping_table_core.sv =====
// Connection mapping table: TABLE_DEPTH entries kept newest first in a chain
// of cells, one entry per cell, handling one beat at a time. An add goes from
// request beat to result beat through capture, decode and commit. Every other
// opcode runs a search wave down the chain, one cell per cycle, and its result
// is committed once the wave leaves the last cell. A delete closes the gap in
// the same cycle its result is registered. A new request is taken once the
// previous result has been registered; the result register holds until the
// downstream side takes it.
module connection_mapping_table_core #(
    parameter int TABLE_DEPTH = cmt_pkg::TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [2:0]  opcode,
    input  logic [15:0] key_id,
    input  logic [31:0] address,
    input  logic [15:0] source_port,
    input  logic [15:0] relay_port,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [1:0]  status,
    output logic [31:0] found_address,
    output logic [15:0] found_source_port,
    output logic [15:0] found_relay_port
);
    import cmt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t      state_reg;
    query_t      query_reg;
    logic        rsp_valid_reg;
    logic [1:0]  status_reg;
    logic [31:0] found_address_reg;
    logic [15:0] found_source_port_reg;
    logic [15:0] found_relay_port_reg;

    entry_t     entries [TABLE_DEPTH];
    entry_t     prev_in [TABLE_DEPTH];
    entry_t     next_in [TABLE_DEPTH];
    carry_t     carries [TABLE_DEPTH];
    carry_t     carry_in [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] waves;
    logic [TABLE_DEPTH-1:0] wave_in;
    logic [TABLE_DEPTH-1:0] valid_vec;

    cell_cmd_t cmd;
    entry_t    new_entry;
    carry_t    last_carry;
    logic      is_add;
    logic      full;
    logic      out_free;
    logic      commit;

    assign is_add     = (query_reg.opcode == OP_ADD_ID) || (query_reg.opcode == OP_ADD_PORT);
    assign full       = entries[TABLE_DEPTH-1].valid;
    assign out_free   = !rsp_valid_reg || rsp_ready;
    assign commit     = (state_reg == S_FINISH) && out_free;
    assign last_carry = carries[TABLE_DEPTH-1];

    always_comb
    begin
        new_entry.valid            = 1'b1;
        new_entry.data.address     = query_reg.address;
        if (query_reg.opcode == OP_ADD_ID)
        begin
            new_entry.data.kind        = KIND_ID;
            new_entry.data.key_id      = query_reg.key_id;
            new_entry.data.source_port = 16'd0;
            new_entry.data.relay_port  = 16'd0;
        end
        else
        begin
            new_entry.data.kind        = KIND_PORT;
            new_entry.data.key_id      = 16'd0;
            new_entry.data.source_port = query_reg.source_port;
            new_entry.data.relay_port  = query_reg.relay_port;
        end
    end

    assign cmd.insert = commit && is_add && !full;
    assign cmd.remove = commit && (query_reg.opcode == OP_DELETE_ID) && last_carry.hit;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign prev_in[gi]  = new_entry;
                assign carry_in[gi] = '0;
                assign wave_in[gi]  = (state_reg == S_START) && !is_add;
            end
            else
            begin : g_body
                assign prev_in[gi]  = entries[gi-1];
                assign carry_in[gi] = carries[gi-1];
                assign wave_in[gi]  = waves[gi-1];
            end
            if (gi == TABLE_DEPTH - 1)
            begin : g_tail
                assign next_in[gi] = '0;
            end
            else
            begin : g_link
                assign next_in[gi] = entries[gi+1];
            end
            assign valid_vec[gi] = entries[gi].valid;

            cmt_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .query      (query_reg),
                .cmd        (cmd),
                .wave_in    (wave_in[gi]),
                .carry_in   (carry_in[gi]),
                .prev_entry (prev_in[gi]),
                .next_entry (next_in[gi]),
                .entry      (entries[gi]),
                .wave_out   (waves[gi]),
                .carry_out  (carries[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (commit)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && rsp_ready)
                rsp_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (req_valid)
                        state_reg <= S_START;
                S_START:
                    state_reg <= is_add ? S_FINISH : S_SCAN;
                S_SCAN:
                    if (waves[TABLE_DEPTH-1])
                        state_reg <= S_FINISH;
                S_FINISH:
                    if (out_free)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            query_reg.opcode      <= opcode;
            query_reg.key_id      <= key_id;
            query_reg.address     <= address;
            query_reg.source_port <= source_port;
            query_reg.relay_port  <= relay_port;
        end
        if (commit)
        begin
            if (is_add)
            begin
                status_reg            <= full ? ST_FULL : ST_OK;
                found_address_reg     <= 32'd0;
                found_source_port_reg <= 16'd0;
                found_relay_port_reg  <= 16'd0;
            end
            else if (last_carry.hit)
            begin
                status_reg            <= ST_OK;
                found_address_reg     <= last_carry.address;
                found_source_port_reg <= last_carry.source_port;
                found_relay_port_reg  <= last_carry.relay_port;
            end
            else
            begin
                status_reg            <= ST_MISS;
                found_address_reg     <= 32'd0;
                found_source_port_reg <= 16'd0;
                found_relay_port_reg  <= 16'd0;
            end
        end
    end

    assign req_ready         = (state_reg == S_IDLE);
    assign rsp_valid         = rsp_valid_reg;
    assign status            = status_reg;
    assign found_address     = found_address_reg;
    assign found_source_port = found_source_port_reg;
    assign found_relay_port  = found_relay_port_reg;

    // At most one cell carries the search wave.
    a_one_wave: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(waves))
        else $error("more than one cell holds the search wave");

    // No wave in flight while a new request can be taken.
    a_idle_no_wave: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> (waves == '0))
        else $error("search wave active while idle");

    // Valid entries always form a prefix from the newest slot.
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec & (valid_vec + 1'b1)) == '0))
        else $error("gap in the valid entries");

    // A result appears only out of the commit state.
    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside commit");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

import cmt_pkg::*;

typedef struct packed {
    logic [1:0]  status;
    logic [31:0] address;
    logic [15:0] source_port;
    logic [15:0] relay_port;
} reply_t;

class mapping_table_model;
    entry_t slots[TABLE_DEPTH_DEF];
    reply_t expected_replies[$];
    int     mismatch_count;

    function new();
        foreach (slots[i]) slots[i] = '0;
        mismatch_count = 0;
    endfunction

    function int live_count();
        int n;
        n = 0;
        foreach (slots[i]) if (slots[i].valid) n++;
        return n;
    endfunction

    function int port_entries();
        int n;
        n = 0;
        foreach (slots[i]) if (slots[i].valid && slots[i].data.kind == KIND_PORT) n++;
        return n;
    endfunction

    function entry_data_t random_live_entry();
        entry_data_t d;
        int          n;
        n = live_count();
        if (n == 0)
        begin
            d.kind        = KIND_ID;
            d.key_id      = 16'($urandom);
            d.address     = $urandom;
            d.source_port = 16'($urandom);
            d.relay_port  = 16'($urandom);
            return d;
        end
        return slots[$urandom_range(n - 1)].data;
    endfunction

    function void apply_request(logic [2:0] op, logic [15:0] id, logic [31:0] addr,
                                logic [15:0] sport, logic [15:0] bport);
        reply_t      r;
        entry_data_t e;
        int          n;
        int          hit;
        int          i;
        logic        match;
        r = '0;
        r.status = ST_MISS;
        if (op == OP_ADD_ID || op == OP_ADD_PORT)
        begin
            e.kind        = (op == OP_ADD_ID) ? KIND_ID : KIND_PORT;
            e.key_id      = (op == OP_ADD_ID) ? id : 16'h0;
            e.address     = addr;
            e.source_port = (op == OP_ADD_PORT) ? sport : 16'h0;
            e.relay_port  = (op == OP_ADD_PORT) ? bport : 16'h0;
            n = live_count();
            if (n >= TABLE_DEPTH_DEF)
                r.status = ST_FULL;
            else
            begin
                // shift older entries down one slot, newest goes to the front
                for (i = n; i > 0; i--) slots[i] = slots[i - 1];
                slots[0].valid = 1'b1;
                slots[0].data  = e;
                r.status = ST_OK;
            end
        end
        else
        begin
            hit = -1;
            for (i = 0; i < TABLE_DEPTH_DEF && hit < 0; i++)
            begin
                match = 1'b0;
                if (slots[i].valid)
                begin
                    case (op)
                        OP_LOOKUP_ID, OP_DELETE_ID:
                            match = slots[i].data.kind == KIND_ID && slots[i].data.key_id == id;
                        OP_FIND_BOUNCE:
                            match = slots[i].data.kind == KIND_PORT &&
                                    slots[i].data.relay_port == bport;
                        OP_FIND_SOURCE:
                            match = slots[i].data.kind == KIND_PORT &&
                                    slots[i].data.source_port == sport &&
                                    slots[i].data.address == addr;
                        default:
                            match = 1'b0;
                    endcase
                end
                if (match) hit = i;
            end
            if (hit >= 0)
            begin
                r.status  = ST_OK;
                r.address = slots[hit].data.address;
                if (op == OP_FIND_BOUNCE || op == OP_FIND_SOURCE)
                begin
                    r.source_port = slots[hit].data.source_port;
                    r.relay_port  = slots[hit].data.relay_port;
                end
                if (op == OP_DELETE_ID)
                begin
                    // close the gap left by the removed entry
                    for (i = hit; i < TABLE_DEPTH_DEF - 1; i++) slots[i] = slots[i + 1];
                    slots[TABLE_DEPTH_DEF - 1].valid = 1'b0;
                end
            end
        end
        expected_replies.push_back(r);
    endfunction

    function void check_reply(logic [1:0] st, logic [31:0] faddr, logic [15:0] fsport,
                              logic [15:0] fbport);
        reply_t want;
        if (expected_replies.size() == 0)
        begin
            $error("unexpected reply beat: status %0d address %h", st, faddr);
            mismatch_count++;
            return;
        end
        want = expected_replies.pop_front();
        if (st !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, st);
            mismatch_count++;
        end
        if (faddr !== want.address)
        begin
            $error("found_address: expected %h, got %h", want.address, faddr);
            mismatch_count++;
        end
        if (fsport !== want.source_port)
        begin
            $error("found_source_port: expected %h, got %h", want.source_port, fsport);
            mismatch_count++;
        end
        if (fbport !== want.relay_port)
        begin
            $error("found_relay_port: expected %h, got %h", want.relay_port, fbport);
            mismatch_count++;
        end
    endfunction
endclass

module tb_top;

    localparam int         DEPTH        = TABLE_DEPTH_DEF;
    localparam int         RANDOM_ITEMS = 1025;
    localparam int         STUCK_LIMIT  = 2000;
    localparam logic [2:0] OP_SPARE_LO  = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [2:0]  opcode = '0;
    logic [15:0] key_id = '0;
    logic [31:0] address = '0;
    logic [15:0] source_port = '0;
    logic [15:0] relay_port = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    logic [1:0]  status;
    logic [31:0] found_address;
    logic [15:0] found_source_port;
    logic [15:0] found_relay_port;

    mapping_table_model table_model = new();

    int burst_left = 0;
    int ready_mode = 0;
    int ready_mode_left = 0;
    int stuck_cycles = 0;

    connection_mapping_table_core #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .opcode(opcode),
        .key_id(key_id),
        .address(address),
        .source_port(source_port),
        .relay_port(relay_port),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .status(status),
        .found_address(found_address),
        .found_source_port(found_source_port),
        .found_relay_port(found_relay_port)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: switch between always ready, coin flip and mostly stalled
    always @(posedge clk)
    begin
        if (ready_mode_left == 0)
        begin
            ready_mode      = $urandom_range(2);
            ready_mode_left = $urandom_range(50, 300);
        end
        else
            ready_mode_left--;
        case (ready_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(1));
            default: rsp_ready <= ($urandom_range(3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                table_model.apply_request(opcode, key_id, address, source_port, relay_port);
            if (rsp_valid && rsp_ready)
                table_model.check_reply(status, found_address, found_source_port,
                                        found_relay_port);
        end
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
    end

    initial
    begin
        while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
        $display("[connection_mapping_table_core] ERROR");
        $finish;
    end

    // drive one request beat and hold it until accepted; gaps come between bursts
    task automatic send_request(input logic [2:0] op, input logic [15:0] id,
                                input logic [31:0] addr, input logic [15:0] sport,
                                input logic [15:0] bport);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid   <= 1'b1;
        opcode      <= op;
        key_id      <= id;
        address     <= addr;
        source_port <= sport;
        relay_port  <= bport;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    task automatic random_request(input int add_pct, input int port_cap);
        logic [2:0]  op;
        logic [15:0] id;
        logic [15:0] sport;
        logic [15:0] bport;
        logic [31:0] addr;
        entry_data_t pick;
        int          r;
        id    = 16'($urandom);
        addr  = $urandom;
        sport = 16'($urandom);
        bport = 16'($urandom);
        pick  = table_model.random_live_entry();
        if ($urandom_range(99) < add_pct)
        begin
            // port entries can never be deleted, so keep their number bounded
            if (table_model.port_entries() < port_cap && $urandom_range(3) == 0)
                op = OP_ADD_PORT;
            else
                op = OP_ADD_ID;
            // draw keys from a narrow pool so duplicates are common
            if ($urandom_range(3) != 0)
                id = $urandom_range(1) ? 16'($urandom_range(7)) : 16'hFFFF - 16'($urandom_range(7));
        end
        else
        begin
            r = $urandom_range(99);
            if (r < 30)
                op = OP_LOOKUP_ID;
            else if (r < 55)
                op = OP_DELETE_ID;
            else if (r < 75)
                op = OP_FIND_BOUNCE;
            else if (r < 95)
                op = OP_FIND_SOURCE;
            else
                op = r[0] ? OP_SPARE_HI : OP_SPARE_LO;
            if ($urandom_range(4) != 0)
            begin
                id    = pick.key_id;
                addr  = pick.address;
                sport = pick.source_port;
                bport = pick.relay_port;
                // near miss: disturb one bit of the search key
                if ($urandom_range(7) == 0)
                begin
                    case ($urandom_range(3))
                        0: addr  ^= 32'(1) << $urandom_range(31);
                        1: sport ^= 16'(1) << $urandom_range(15);
                        2: bport ^= 16'(1) << $urandom_range(15);
                        default: id ^= 16'(1) << $urandom_range(15);
                    endcase
                end
            end
        end
        send_request(op, id, addr, sport, bport);
    endtask

    initial
    begin
        int items_left;
        int add_pct;
        int run_len;
        int k;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: every search misses, spare opcodes miss
        send_request(OP_LOOKUP_ID, 16'h0000, 32'h0, 16'h0, 16'h0);
        send_request(OP_FIND_BOUNCE, 16'h0000, 32'h0, 16'h0, 16'h0);
        send_request(OP_FIND_SOURCE, 16'h0000, 32'h0, 16'h0, 16'h0);
        send_request(OP_DELETE_ID, 16'h0000, 32'h0, 16'h0, 16'h0);
        send_request(OP_SPARE_LO, 16'($urandom), $urandom, 16'($urandom), 16'($urandom));
        send_request(OP_SPARE_HI, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        // all-zero id and port entries: the kind bit must keep them apart
        send_request(OP_ADD_ID, 16'h0000, 32'h0, 16'hFFFF, 16'hFFFF);
        send_request(OP_ADD_PORT, 16'hFFFF, 32'h0, 16'h0, 16'h0);
        send_request(OP_LOOKUP_ID, 16'h0000, 32'h0, 16'h0, 16'h0);
        send_request(OP_FIND_BOUNCE, 16'h0000, 32'h0, 16'h0, 16'h0);
        send_request(OP_FIND_SOURCE, 16'h0000, 32'h0, 16'h0, 16'h0);
        // all-ones entries and a newer duplicate id
        send_request(OP_ADD_ID, 16'hFFFF, 32'hFFFF_FFFF, 16'h0, 16'h0);
        send_request(OP_ADD_PORT, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_request(OP_ADD_ID, 16'h0000, 32'h1234_5678, 16'h0, 16'h0);
        send_request(OP_LOOKUP_ID, 16'h0000, 32'h0, 16'h0, 16'h0);
        send_request(OP_FIND_BOUNCE, 16'h0000, 32'h0, 16'h0, 16'hFFFF);
        send_request(OP_FIND_SOURCE, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF, 16'h0);
        send_request(OP_FIND_SOURCE, 16'h0000, 32'hFFFF_FFFE, 16'hFFFF, 16'h0);
        send_request(OP_FIND_SOURCE, 16'h0000, 32'hFFFF_FFFF, 16'hFFFE, 16'h0);
        // delete takes the newest match, the older one then shows through
        send_request(OP_DELETE_ID, 16'h0000, 32'h0, 16'h0, 16'h0);
        send_request(OP_LOOKUP_ID, 16'h0000, 32'h0, 16'h0, 16'h0);
        send_request(OP_DELETE_ID, 16'hFFFF, 32'h0, 16'h0, 16'h0);
        send_request(OP_LOOKUP_ID, 16'hFFFF, 32'h0, 16'h0, 16'h0);
        send_request(OP_DELETE_ID, 16'h0000, 32'h0, 16'h0, 16'h0);
        send_request(OP_DELETE_ID, 16'h0000, 32'h0, 16'h0, 16'h0);

        // runs with varying add pressure so the table fills, hits full and drains
        items_left = RANDOM_ITEMS;
        while (items_left > 0)
        begin
            add_pct = 20 + 25 * $urandom_range(3);
            run_len = $urandom_range(20, 80);
            for (k = 0; k < run_len && items_left > 0; k++)
            begin
                random_request(add_pct, (items_left < 120) ? DEPTH : 5);
                items_left--;
            end
        end

        req_valid <= 1'b0;
        @(posedge clk);
        while (table_model.expected_replies.size() != 0) @(posedge clk);
        repeat (2 * DEPTH + 8) @(posedge clk);
        if (table_model.mismatch_count == 0 && table_model.expected_replies.size() == 0)
            $display("[connection_mapping_table_core] OK");
        else
            $display("[connection_mapping_table_core] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/cmt_pkg.sv
hdl/cmt_cell.sv
hdl/connection_mapping_table_core.sv
tb/tb_top.sv
